### design/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg: shared types and constants for the descriptor medoid selector
// Sizes of the descriptor set, operation codes, the evaluation state type and
// the small helper functions used by the bit counter, the sequencer and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

	// Set geometry.
	localparam int MAX_VIEWS  = 32;
	localparam int DESC_WORDS = 4;
	localparam int WORD_BITS  = 64;

	localparam int SLOT_W = $clog2(MAX_VIEWS);
	localparam int CNT_W  = $clog2(MAX_VIEWS + 1);
	localparam int WORD_W = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
	localparam int ADDR_W = $clog2(MAX_VIEWS * DESC_WORDS);

	// Fixed port widths.
	localparam int OP_W       = 2;
	localparam int WIDX_W     = 2;
	localparam int ASSOC_W    = 16;
	localparam int OUT_SLOT_W = 5;
	localparam int OUT_SUM_W  = 13;
	localparam int OUT_CNT_W  = 6;

	// Internal sum of distances for one descriptor, before saturation.
	localparam int SUM_W = $clog2(MAX_VIEWS * DESC_WORDS * WORD_BITS + 1);
	localparam logic [SUM_W-1:0] SUM_SAT = SUM_W'((1 << OUT_SUM_W) - 1);

	// Digit-serial population count.
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = WORD_BITS / DIGIT_W;
	localparam int DIGIT_CW   = $clog2(DIGIT_W + 1);
	localparam int BITCNT_W   = $clog2(WORD_BITS + 1);
	localparam int REM_W      = $clog2(DIGITS + 1);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_EVAL  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		EV_IDLE,
		EV_READ,
		EV_LOAD,
		EV_COUNT,
		EV_CMP,
		EV_ASSOC,
		EV_FINISH
	} eval_state_t;

	// Write requests into the descriptor and keypoint stores.
	typedef struct packed {
		logic                 desc_en;
		logic [ADDR_W-1:0]    desc_addr;
		logic [WORD_BITS-1:0] desc_data;
		logic                 assoc_en;
		logic [SLOT_W-1:0]    assoc_slot;
		logic [ASSOC_W-1:0]   assoc_data;
	} store_wr_t;

	// Outcome of one evaluation, valid for one cycle.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [SUM_W-1:0]  sum;
	} eval_res_t;

	function automatic logic [ADDR_W-1:0] desc_addr(input logic [SLOT_W-1:0] slot,
		input logic [WORD_W-1:0] w);
		desc_addr = ADDR_W'(slot) * ADDR_W'(DESC_WORDS) + ADDR_W'(w);
	endfunction

	function automatic logic [DIGIT_CW-1:0] digit_ones(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_CW-1:0] n;
		n = '0;
		for (int k = 0; k < DIGIT_W; k++) begin
			n = n + DIGIT_CW'(d[k]);
		end
		digit_ones = n;
	endfunction

endpackage

`default_nettype wire

### design/dms_store.sv
// ----------------------------------------------------------------------------
// dms_store: descriptor and keypoint index memories
// One write port per memory, two registered read ports on the descriptor
// words and one registered read port on the keypoint indices.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_store
	import dms_pkg::*;
(
	input  wire logic                 clk,
	input  wire store_wr_t            wr,
	input  wire logic [ADDR_W-1:0]    rd_addr_a,
	input  wire logic [ADDR_W-1:0]    rd_addr_b,
	input  wire logic [SLOT_W-1:0]    assoc_rd_slot,
	output      logic [WORD_BITS-1:0] rd_data_a,
	output      logic [WORD_BITS-1:0] rd_data_b,
	output      logic [ASSOC_W-1:0]   assoc_rd_data
);

	logic [WORD_BITS-1:0] desc_mem [MAX_VIEWS*DESC_WORDS];
	logic [ASSOC_W-1:0]   assoc_mem [MAX_VIEWS];

	always_ff @(posedge clk) begin
		if (wr.desc_en) begin
			desc_mem[wr.desc_addr] <= wr.desc_data;
		end
		rd_data_a <= desc_mem[rd_addr_a];
		rd_data_b <= desc_mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		if (wr.assoc_en) begin
			assoc_mem[wr.assoc_slot] <= wr.assoc_data;
		end
		assoc_rd_data <= assoc_mem[assoc_rd_slot];
	end

endmodule

`default_nettype wire

### design/dms_bit_counter.sv
// ----------------------------------------------------------------------------
// dms_bit_counter: digit-serial population count of one word
// The word is shifted out DIGIT_W bits a cycle and the ones are summed.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_bit_counter
	import dms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire logic [WORD_BITS-1:0] data,
	output      logic                 done,
	output      logic [BITCNT_W-1:0]  count
);

	logic [WORD_BITS-1:0] shift_q;
	logic [BITCNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic                 active_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			rem_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				active_q <= 1'b1;
				rem_q    <= REM_W'(DIGITS);
			end else if (active_q) begin
				rem_q <= rem_q - REM_W'(1);
				if (rem_q == REM_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= data;
			cnt_q   <= '0;
		end else if (active_q) begin
			shift_q <= shift_q >> DIGIT_W;
			cnt_q   <= cnt_q + BITCNT_W'(digit_ones(shift_q[DIGIT_W-1:0]));
		end
	end

	assign done  = done_q;
	assign count = cnt_q;

endmodule

`default_nettype wire

### design/dms_eval.sv
// ----------------------------------------------------------------------------
// dms_eval: medoid search sequencer
// Walks every pair of stored descriptors word by word, sums the Hamming
// distances per descriptor and keeps the first one with the least sum.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_eval
	import dms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [CNT_W-1:0]     n_entries,
	input  wire logic [WORD_BITS-1:0] rd_data_a,
	input  wire logic [WORD_BITS-1:0] rd_data_b,
	output      logic [ADDR_W-1:0]    rd_addr_a,
	output      logic [ADDR_W-1:0]    rd_addr_b,
	output      logic [SLOT_W-1:0]    assoc_rd_slot,
	output      logic                 busy,
	output      eval_res_t            res
);

	eval_state_t state_q, state_d;

	logic [SLOT_W-1:0] i_q, j_q, best_q;
	logic [WORD_W-1:0] w_q;
	logic [SUM_W-1:0]  acc_q, best_sum_q;
	logic              found_q;

	logic                cnt_load;
	logic                cnt_done;
	logic [BITCNT_W-1:0] cnt_value;

	logic last_word, last_j, last_i;

	assign last_word = (w_q == WORD_W'(DESC_WORDS - 1));
	assign last_j    = (CNT_W'(j_q) == n_entries - CNT_W'(1));
	assign last_i    = (CNT_W'(i_q) == n_entries - CNT_W'(1));

	dms_bit_counter u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cnt_load),
		.data   (rd_data_a ^ rd_data_b),
		.done   (cnt_done),
		.count  (cnt_value)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EV_IDLE: begin
				if (go) begin
					state_d = (n_entries == '0) ? EV_ASSOC : EV_READ;
				end
			end
			EV_READ:  state_d = EV_LOAD;
			EV_LOAD:  state_d = EV_COUNT;
			EV_COUNT: begin
				if (cnt_done) begin
					state_d = (last_word && last_j) ? EV_CMP : EV_READ;
				end
			end
			EV_CMP:    state_d = last_i ? EV_ASSOC : EV_READ;
			EV_ASSOC:  state_d = EV_FINISH;
			EV_FINISH: state_d = EV_IDLE;
			default:   state_d = EV_IDLE;
		endcase
	end

	always_comb begin
		busy          = (state_q != EV_IDLE);
		cnt_load      = (state_q == EV_LOAD);
		rd_addr_a     = desc_addr(i_q, w_q);
		rd_addr_b     = desc_addr(j_q, w_q);
		assoc_rd_slot = best_q;
		res.valid     = (state_q == EV_FINISH);
		res.found     = found_q;
		res.slot      = best_q;
		res.sum       = best_sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= EV_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			w_q        <= '0;
			acc_q      <= '0;
			best_q     <= '0;
			best_sum_q <= '0;
			found_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				EV_IDLE: begin
					if (go) begin
						i_q        <= '0;
						j_q        <= '0;
						w_q        <= '0;
						acc_q      <= '0;
						best_q     <= '0;
						best_sum_q <= '0;
						found_q    <= 1'b0;
					end
				end
				EV_COUNT: begin
					if (cnt_done) begin
						acc_q <= acc_q + SUM_W'(cnt_value);
						if (last_word) begin
							w_q <= '0;
							if (!last_j) begin
								j_q <= j_q + SLOT_W'(1);
							end
						end else begin
							w_q <= w_q + WORD_W'(1);
						end
					end
				end
				EV_CMP: begin
					// Strict less-than keeps the earliest slot on ties.
					if (!found_q || acc_q < best_sum_q) begin
						found_q    <= 1'b1;
						best_q     <= i_q;
						best_sum_q <= acc_q;
					end
					acc_q <= '0;
					j_q   <= '0;
					w_q   <= '0;
					if (!last_i) begin
						i_q <= i_q + SLOT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/descriptor_medoid_select_core.sv
// ----------------------------------------------------------------------------
// descriptor_medoid_select_core: medoid of a set of binary descriptors
// Stores up to MAX_VIEWS descriptors and picks the one whose summed Hamming
// distance to the whole set is least.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge with start high and busy low.
// op selects the action: load one 64-bit descriptor word (word_index gives
// its place; the last word completes the entry and takes assoc_index), clear
// the set, or evaluate. Loads and clears never raise busy, so a new request
// may follow in every cycle. A load into a full set is dropped and sets the
// sticky overflow flag; clear resets the count and the flag but leaves memory
// contents in place.
// An evaluate raises busy while the sequencer walks every ordered pair of
// stored descriptors, one 64-bit word at a time. Each word pair passes a
// memory read, a transfer and a 4-bit-per-cycle population count with its
// finish step. The result appears on the output ports with done high for
// one cycle, in the first cycle with busy low. The result ports hold their
// value until the next evaluation finishes.
// The receiver cannot stall: done is a strobe and must be sampled at once.
// Reset (arst_n low) empties the set and clears overflow; descriptor memory
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_medoid_select_core
	import dms_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [WORD_BITS-1:0]  desc_word,
	input  wire logic [WIDX_W-1:0]     word_index,
	input  wire logic [ASSOC_W-1:0]    assoc_index,
	output      logic                  done,
	output      logic                  found,
	output      logic [OUT_SLOT_W-1:0] best_slot,
	output      logic [ASSOC_W-1:0]    best_assoc,
	output      logic [OUT_SUM_W-1:0]  best_sum,
	output      logic [OUT_CNT_W-1:0]  entry_count,
	output      logic                  overflow
);

	logic [CNT_W-1:0] set_count_q;
	logic             overflow_q;
	logic             accept;
	logic             is_full;
	logic             word_ok;
	logic             eval_go;
	store_wr_t        wr;

	logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
	logic [WORD_BITS-1:0] rd_data_a, rd_data_b;
	logic [SLOT_W-1:0]    assoc_rd_slot;
	logic [ASSOC_W-1:0]   assoc_rd_data;
	logic                 eval_busy;
	eval_res_t            res;
	logic [SUM_W-1:0]     sum_sat;

	// Output registers.
	logic                  done_q;
	logic                  found_q;
	logic [OUT_SLOT_W-1:0] best_slot_q;
	logic [ASSOC_W-1:0]    best_assoc_q;
	logic [OUT_SUM_W-1:0]  best_sum_q;
	logic [OUT_CNT_W-1:0]  entry_count_q;
	logic                  overflow_out_q;

	assign accept  = start && !busy;
	assign is_full = (set_count_q >= CNT_W'(MAX_VIEWS));
	assign word_ok = (int'(word_index) < DESC_WORDS);
	assign eval_go = accept && (op == OP_EVAL);

	// Write request for a load: the word goes to the slot being filled, the
	// keypoint index and the count advance only with the completing word.
	always_comb begin
		wr.desc_en    = accept && (op == OP_LOAD) && !is_full && word_ok;
		wr.desc_addr  = desc_addr(set_count_q[SLOT_W-1:0], WORD_W'(word_index));
		wr.desc_data  = desc_word;
		wr.assoc_en   = wr.desc_en && (int'(word_index) == DESC_WORDS - 1);
		wr.assoc_slot = set_count_q[SLOT_W-1:0];
		wr.assoc_data = assoc_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q <= '0;
			overflow_q  <= 1'b0;
		end else if (accept) begin
			unique case (op)
				OP_LOAD: begin
					if (is_full) begin
						overflow_q <= 1'b1;
					end else if (wr.assoc_en) begin
						set_count_q <= set_count_q + CNT_W'(1);
					end
				end
				OP_CLEAR: begin
					set_count_q <= '0;
					overflow_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	dms_store u_store (
		.clk           (clk),
		.wr            (wr),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.assoc_rd_slot (assoc_rd_slot),
		.rd_data_a     (rd_data_a),
		.rd_data_b     (rd_data_b),
		.assoc_rd_data (assoc_rd_data)
	);

	dms_eval u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (eval_go),
		.n_entries     (set_count_q),
		.rd_data_a     (rd_data_a),
		.rd_data_b     (rd_data_b),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.assoc_rd_slot (assoc_rd_slot),
		.busy          (eval_busy),
		.res           (res)
	);

	assign busy    = eval_busy;
	assign sum_sat = (res.sum > SUM_SAT) ? SUM_SAT : res.sum;

	// The keypoint index read is issued in EV_ASSOC, before the result is valid
	// in EV_FINISH, so it arrives together with it. Nothing loads during busy,
	// so the count and flag still describe the evaluated set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			found_q        <= res.found;
			best_slot_q    <= res.found ? OUT_SLOT_W'(res.slot) : '0;
			best_assoc_q   <= res.found ? assoc_rd_data : '0;
			best_sum_q     <= res.found ? OUT_SUM_W'(sum_sat) : '0;
			entry_count_q  <= OUT_CNT_W'(set_count_q);
			overflow_out_q <= overflow_q;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign best_slot   = best_slot_q;
	assign best_assoc  = best_assoc_q;
	assign best_sum    = best_sum_q;
	assign entry_count = entry_count_q;
	assign overflow    = overflow_out_q;

	// A result strobe always closes a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding evaluation");

	// Busy only starts on an accepted evaluate request.
	a_busy_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && op == OP_EVAL))
		else $error("busy raised without an evaluate request");

	// A chosen descriptor lies inside the set.
	a_slot_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (OUT_CNT_W'(best_slot) < entry_count))
		else $error("chosen slot outside the stored set");

	// An empty set reports all-zero selection fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (best_slot == '0 && best_sum == '0 && best_assoc == '0))
		else $error("selection fields not zero for an empty set");

endmodule

`default_nettype wire
